// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the text console writer.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define TCW_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("tcw: assertion failed");

// Checks that a consequent holds whenever an antecedent holds, outside reset.
`define TCW_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tcw: assertion failed");

`endif

// ----- hdl/tcw_pkg.sv -----
// ---------------------------------------------------------------------------
// Text console writer package
// Geometry, character codes, opcodes and the control structs shared by the
// controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int TAB_WIDTH = 8;

    localparam int CELLS        = ROWS * COLUMNS;
    localparam int SCROLL_CELLS = (ROWS - 1) * COLUMNS;

    localparam int CELL_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int TAB_W  = $clog2(TAB_WIDTH);
    localparam int CX_W   = $clog2(COLUMNS + TAB_WIDTH);

    localparam int OPCODE_W = 2;
    localparam int CHAR_W   = 8;
    localparam int ADDR_W   = 11;
    localparam int DATA_W   = 16;
    localparam int OFFS_W   = 11;

    localparam logic [DATA_W-1:0] BLANK_CELL = 16'h0F20;
    localparam logic [CHAR_W-1:0] TEXT_ATTR  = 8'h0F;

    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } t_opcode;

    typedef struct packed {
        logic load_item;
        logic exec;
        logic sweep_step;
        logic sweep_blank;
        logic read_capture;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic                scroll;
        logic                sweep_last;
        logic                out_free;
    } t_status;

endpackage

`default_nettype wire

// ----- hdl/tcw_ram.sv -----
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hdl/tcw_ctrl.sv -----
// ---------------------------------------------------------------------------
// Text console writer controller
// Sequences reset clearing, item execution, store sweeps, reads and the
// hand-over of each result to the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl
    import tcw_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    typedef enum logic [2:0] {
        S_INIT,
        S_INIT_END,
        S_IDLE,
        S_EXEC,
        S_SWEEP,
        S_FLUSH,
        S_RDATA,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_blank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_blank <= 1'b1;
        end else begin
            unique case (r_state)
                S_INIT: begin
                    if (i_status.sweep_last) begin
                        r_state <= S_INIT_END;
                    end
                end
                S_INIT_END: begin
                    r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (i_status.opcode == OP_PUT && i_status.scroll) begin
                        r_blank <= 1'b0;
                        r_state <= S_SWEEP;
                    end else if (i_status.opcode == OP_CLEAR) begin
                        r_blank <= 1'b1;
                        r_state <= S_SWEEP;
                    end else if (i_status.opcode == OP_READ) begin
                        r_state <= S_RDATA;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_SWEEP: begin
                    if (i_status.sweep_last) begin
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    r_state <= S_DONE;
                end
                S_RDATA: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_status.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_INIT;
                end
            endcase
        end
    end

    always_comb begin
        o_ready              = (r_state == S_IDLE);
        o_cmd.load_item      = (r_state == S_IDLE) && i_valid;
        o_cmd.exec           = (r_state == S_EXEC);
        o_cmd.sweep_step     = (r_state == S_INIT) || (r_state == S_SWEEP);
        o_cmd.sweep_blank    = r_blank;
        o_cmd.read_capture   = (r_state == S_RDATA);
        o_cmd.out_load       = (r_state == S_DONE) && i_status.out_free;
    end

endmodule

`default_nettype wire

// ----- hdl/tcw_dp.sv -----
// ---------------------------------------------------------------------------
// Text console writer datapath
// Holds the item, the cursor, the cell store with its sweep pipeline and the
// output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tcw_dp
    import tcw_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    output t_status                  o_status,
    input  wire logic [OPCODE_W-1:0] i_opcode,
    input  wire logic [CHAR_W-1:0]   i_char_code,
    input  wire logic [ADDR_W-1:0]   i_cell_address,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [DATA_W-1:0]        o_cell_data,
    output logic [OFFS_W-1:0]        o_cursor_offset
);

    logic [OPCODE_W-1:0] r_opcode;
    logic [CHAR_W-1:0]   r_char;
    logic [ADDR_W-1:0]   r_item_addr;

    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_row;
    logic [TAB_W-1:0]    r_tab;
    logic [CELL_W-1:0]   r_off;

    logic [CELL_W-1:0]   r_sweep;
    logic                r_wr_valid;
    logic [CELL_W-1:0]   r_wr_addr;
    logic                r_wr_blank;

    logic [DATA_W-1:0]   r_res_data;
    logic                r_addr_ok;

    logic                r_out_valid;
    logic [DATA_W-1:0]   r_out_data;
    logic [OFFS_W-1:0]   r_out_off;

    logic                is_bs;
    logic                is_tab;
    logic                is_cr;
    logic                is_lf;
    logic                is_print;
    logic [CX_W-1:0]     col_x;
    logic                row_inc;
    logic                scroll;
    logic [CELL_W-1:0]   row_start;
    logic [COL_W-1:0]    n_col;
    logic [ROW_W-1:0]    n_row;
    logic [TAB_W-1:0]    n_tab;
    logic [CELL_W-1:0]   n_off;

    logic                sweep_last;
    logic                put_wr;
    logic                ram_we;
    logic [CELL_W-1:0]   ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic [CELL_W-1:0]   ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;

    always_comb begin
        is_bs     = (r_char == CH_BS);
        is_tab    = (r_char == CH_TAB);
        is_cr     = (r_char == CH_CR);
        is_lf     = (r_char == CH_LF);
        is_print  = (r_char >= CH_SPACE) && !r_char[CHAR_W-1];
        row_start = r_off - CELL_W'(r_col);
        col_x     = CX_W'(r_col);
        n_tab     = r_tab;
        if (is_bs) begin
            if (r_col != '0) begin
                col_x = CX_W'(r_col) - CX_W'(1);
                n_tab = (r_tab == '0) ? TAB_W'(TAB_WIDTH - 1) : r_tab - TAB_W'(1);
            end
        end else if (is_tab) begin
            col_x = CX_W'(r_col) - CX_W'(r_tab) + CX_W'(TAB_WIDTH);
            n_tab = '0;
        end else if (is_cr || is_lf) begin
            col_x = '0;
            n_tab = '0;
        end else if (is_print) begin
            col_x = CX_W'(r_col) + CX_W'(1);
            n_tab = (r_tab == TAB_W'(TAB_WIDTH - 1)) ? '0 : r_tab + TAB_W'(1);
        end
        row_inc = is_lf || (col_x >= CX_W'(COLUMNS));
        scroll  = row_inc && (r_row == ROW_W'(ROWS - 1));
        if (row_inc) begin
            n_col = '0;
            n_tab = '0;
            n_row = scroll ? r_row : r_row + ROW_W'(1);
            n_off = scroll ? row_start : row_start + CELL_W'(COLUMNS);
        end else begin
            n_col = COL_W'(col_x);
            n_row = r_row;
            n_off = row_start + CELL_W'(col_x);
        end
    end

    assign sweep_last = (r_sweep == CELL_W'(CELLS - 1));
    assign put_wr     = i_cmd.exec && (r_opcode == OP_PUT) && is_print;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_opcode    <= i_opcode;
            r_char      <= i_char_code;
            r_item_addr <= i_cell_address;
        end
        if (i_cmd.sweep_step) begin
            r_wr_addr  <= r_sweep;
            r_wr_blank <= i_cmd.sweep_blank || (32'(r_sweep) >= SCROLL_CELLS);
        end
        if (i_cmd.exec) begin
            r_res_data <= '0;
            r_addr_ok  <= (32'(r_item_addr) < CELLS);
        end else if (i_cmd.read_capture) begin
            r_res_data <= r_addr_ok ? ram_rdata : '0;
        end
        if (i_cmd.out_load) begin
            r_out_data <= r_res_data;
            r_out_off  <= OFFS_W'(r_off);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_tab       <= '0;
            r_off       <= '0;
            r_sweep     <= '0;
            r_wr_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_valid <= i_cmd.sweep_step;
            if (i_cmd.sweep_step) begin
                r_sweep <= sweep_last ? '0 : r_sweep + CELL_W'(1);
            end
            if (i_cmd.exec && r_opcode == OP_PUT) begin
                r_col <= n_col;
                r_row <= n_row;
                r_tab <= n_tab;
                r_off <= n_off;
            end else if (i_cmd.exec && r_opcode == OP_CLEAR) begin
                r_col <= '0;
                r_row <= '0;
                r_tab <= '0;
                r_off <= '0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        ram_we    = r_wr_valid || put_wr;
        ram_waddr = r_wr_valid ? r_wr_addr : r_off;
        if (r_wr_valid) begin
            ram_wdata = r_wr_blank ? BLANK_CELL : ram_rdata;
        end else begin
            ram_wdata = {TEXT_ATTR, r_char};
        end
        ram_raddr = i_cmd.sweep_step ? r_sweep + CELL_W'(COLUMNS) : CELL_W'(r_item_addr);
    end

    tcw_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_status.opcode     = r_opcode;
        o_status.scroll     = scroll;
        o_status.sweep_last = sweep_last;
        o_status.out_free   = !r_out_valid || i_ready;
    end

    assign o_valid         = r_out_valid;
    assign o_cell_data     = r_out_data;
    assign o_cursor_offset = r_out_off;

    // A cell write from a put never lands while a sweep write is draining.
    `TCW_ASSERT(a_wr_clash, !(r_wr_valid && put_wr))
    // The cursor always lies inside the screen.
    `TCW_ASSERT(a_cursor_bounds, (32'(r_col) < COLUMNS) && (32'(r_row) < ROWS))
    // The running offset follows the row and column.
    `TCW_ASSERT(a_offset_track, r_off == CELL_W'(CELL_W'(r_row) * CELL_W'(COLUMNS)) + CELL_W'(r_col))
    // Once a sweep has fully drained, the sweep counter is back at the start.
    `TCW_ASSERT_IMP(a_sweep_rest, !i_cmd.sweep_step && !r_wr_valid, r_sweep == '0)

endmodule

`default_nettype wire

// ----- hdl/text_console_writer_top.sv -----
// ---------------------------------------------------------------------------
// Text console writer
// Text-mode console over a store of 16-bit cells: puts characters with
// cursor control, scrolls, clears and reads back single cells.
//
//   Channel  Handshake          Payload
//   input    i_valid / o_ready  i_opcode, i_char_code, i_cell_address
//   output   o_valid / i_ready  o_cell_data, o_cursor_offset
//
// From acceptance, a put that does not scroll passes S_EXEC and S_DONE before
// the result register loads, and a read passes S_EXEC, S_RDATA and S_DONE. A
// scroll or a clear sweeps the whole cell memory through its single write
// port, one cell a cycle, then passes S_FLUSH and S_DONE. After reset the
// same sweep blanks the memory before the first item is accepted.
// The output register holds a stalled result while the next item is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module text_console_writer_top
    import tcw_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [OPCODE_W-1:0] i_opcode,
    input  wire logic [CHAR_W-1:0]   i_char_code,
    input  wire logic [ADDR_W-1:0]   i_cell_address,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [DATA_W-1:0]        o_cell_data,
    output logic [OFFS_W-1:0]        o_cursor_offset
);

    t_cmd    cmd;
    t_status status;

    tcw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    tcw_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_opcode        (i_opcode),
        .i_char_code     (i_char_code),
        .i_cell_address  (i_cell_address),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_cell_data     (o_cell_data),
        .o_cursor_offset (o_cursor_offset)
    );

endmodule

`default_nettype wire
